/* hdl/id3yfe_pkg.sv */
// ----------------------------------------------------------------------------
// ID3 year frame extractor package
// Parse phases, verdict codes and fixed constants of the ID3v2.3 text frame
// extractor.
// ----------------------------------------------------------------------------
package id3yfe_pkg;

  // Number of text characters taken from the wanted frame.
  localparam int YEAR_CHARS = 4;

  // Default wanted frame identifier, "TYER".
  localparam logic [31:0] DEFAULT_FRAME_ID = 32'h5459_4552;

  // Extended header length, CRC length, frame header length and frame flag bytes.
  localparam logic [29:0] EXT_HEADER_BYTES = 30'd10;
  localparam logic [29:0] CRC_DATA_BYTES   = 30'd4;
  localparam logic [32:0] FRAME_HDR_BYTES  = 33'd10;
  localparam logic [29:0] FRAME_TAIL_BYTES = 30'd2;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_MAGIC   = 4'd1,
    PH_VERSION = 4'd2,
    PH_FLAGS   = 4'd3,
    PH_SIZE    = 4'd4,
    PH_EXT     = 4'd5,
    PH_CRC     = 4'd6,
    PH_FID     = 4'd7,
    PH_FSIZE   = 4'd8,
    PH_SKIP    = 4'd9,
    PH_FFLAGS  = 4'd10,
    PH_ENC     = 4'd11,
    PH_YEAR    = 4'd12,
    PH_TERM    = 4'd13
  } phase_t;

  typedef enum logic [3:0] {
    ST_FOUND       = 4'd0,
    ST_NO_TAG      = 4'd1,
    ST_BAD_FLAGS   = 4'd2,
    ST_BAD_EXT     = 4'd3,
    ST_FRAME_FLAGS = 4'd4,
    ST_ENCODING    = 4'd5,
    ST_SHORT       = 4'd6,
    ST_TERM        = 4'd7,
    ST_ABSENT      = 4'd8,
    ST_TRUNC       = 4'd9
  } status_t;

  // Expected tag identifier "ID3", one byte per position.
  function automatic logic [7:0] magic_byte(input logic [3:0] pos);
    logic [7:0] val;
    case (pos)
      4'd0:    val = 8'h49;
      4'd1:    val = 8'h44;
      4'd2:    val = 8'h33;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

/* hdl/id3_year_frame_extractor_unit.sv */
// Path: an accepted byte is held in the input register, and its verdict is
// registered in the result register that drives out_tvalid.
// Throughput: one byte per cycle; bytes stall only while a verdict waits
// unread on the result stream.
// Reset (rst_n low, synchronous): parser idle, no result pending,
// wanted_frame_id back to "TYER".
// ----------------------------------------------------------------------------
// ID3 year frame extractor
// Walks an ID3v2.3 tag byte by byte, finds the wanted text frame and returns
// one verdict per stream with the frame's first four characters.
// ----------------------------------------------------------------------------
module id3_year_frame_extractor_unit (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] start_of_stream
  input  logic        in_tlast,   // end_of_stream
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [3:0] status, [35:4] year_text, [39:36] zero
  // Configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data    // wanted_frame_id
);

  import id3yfe_pkg::*;

  // Configuration register
  logic [31:0] wanted_id_r;

  // Input register
  logic       in_v_r;
  logic [7:0] in_byte_r;
  logic       in_sos_r;
  logic       in_eos_r;

  // Parser state
  phase_t      phase_r, phase_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic [29:0] tag_r, tag_nxt;
  logic [31:0] flen_r, flen_nxt;
  logic [7:0]  flag_r, flag_nxt;
  logic [31:0] id_r, id_nxt;
  logic [31:0] year_r, year_nxt;
  logic [29:0] skip_r, skip_nxt;

  // Result register
  logic        out_v_r;
  status_t     out_status_r;
  logic [31:0] out_year_r;

  // State seen by the current byte, after a stream restart
  phase_t      cur_phase;
  logic [3:0]  cur_pos;
  logic [29:0] cur_tag;
  logic [31:0] cur_flen;
  logic [7:0]  cur_flag;
  logic [31:0] cur_id;
  logic [31:0] cur_year;
  logic [29:0] cur_skip;

  // Per-byte working values
  logic        adv;
  logic        verdict_v;
  status_t     verdict_st;
  logic [31:0] verdict_year;
  logic [29:0] tag_new;
  logic [29:0] tag_avail;
  logic [31:0] flen_new;
  logic [31:0] year_new;
  logic [32:0] need;
  logic [7:0]  flag_v;
  logic        enter;

  // Configuration is always accepted.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wanted_id_r <= DEFAULT_FRAME_ID;
    end else if (cfg_valid) begin
      wanted_id_r <= cfg_data;
    end
  end

  // The input register advances when the result slot is free or draining.
  assign adv       = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      in_byte_r <= in_tdata;
      in_sos_r  <= in_tuser;
      in_eos_r  <= in_tlast;
    end
  end

  // A start-of-stream beat restarts the parser from cleared state.
  always_comb begin
    if (in_sos_r) begin
      cur_phase = PH_MAGIC;
      cur_pos   = '0;
      cur_tag   = '0;
      cur_flen  = '0;
      cur_flag  = '0;
      cur_id    = '0;
      cur_year  = '0;
      cur_skip  = '0;
    end else begin
      cur_phase = phase_r;
      cur_pos   = pos_r;
      cur_tag   = tag_r;
      cur_flen  = flen_r;
      cur_flag  = flag_r;
      cur_id    = id_r;
      cur_year  = year_r;
      cur_skip  = skip_r;
    end
  end

  // Shifted and derived values of the current byte.
  assign tag_new  = {cur_tag[22:0], in_byte_r[6:0]};
  assign flen_new = {cur_flen[23:0], in_byte_r};
  assign year_new = {cur_year[23:0], in_byte_r};
  assign need     = {1'b0, flen_new} + FRAME_HDR_BYTES;

  // Next parser state and verdict for the byte in the input register.
  always_comb begin
    phase_nxt    = cur_phase;
    pos_nxt      = cur_pos + 4'd1;
    tag_nxt      = cur_tag;
    flen_nxt     = cur_flen;
    flag_nxt     = cur_flag;
    id_nxt       = cur_id;
    year_nxt     = cur_year;
    skip_nxt     = cur_skip;
    verdict_v    = 1'b0;
    verdict_st   = ST_FOUND;
    verdict_year = '0;
    tag_avail    = cur_tag;
    flag_v       = cur_flag;
    enter        = 1'b0;

    case (cur_phase)
      PH_MAGIC: begin
        if (cur_pos > 4'd2 || in_byte_r != magic_byte(cur_pos)) begin
          verdict_v  = 1'b1;
          verdict_st = ST_NO_TAG;
        end else if (cur_pos == 4'd2) begin
          phase_nxt = PH_VERSION;
          pos_nxt   = '0;
        end
      end
      PH_VERSION: begin
        if (cur_pos >= 4'd1) begin
          phase_nxt = PH_FLAGS;
          pos_nxt   = '0;
        end
      end
      PH_FLAGS: begin
        if (in_byte_r[4:0] != 5'd0) begin
          verdict_v  = 1'b1;
          verdict_st = ST_BAD_FLAGS;
        end else begin
          flag_nxt  = in_byte_r;
          phase_nxt = PH_SIZE;
          pos_nxt   = '0;
          tag_nxt   = '0;
        end
      end
      PH_SIZE: begin
        tag_nxt = tag_new;
        if (cur_pos >= 4'd3) begin
          if (cur_flag[6]) begin
            tag_nxt   = (tag_new > EXT_HEADER_BYTES) ? tag_new - EXT_HEADER_BYTES : '0;
            phase_nxt = PH_EXT;
            pos_nxt   = '0;
          end else begin
            tag_avail = tag_new;
            enter     = 1'b1;
          end
        end
      end
      PH_EXT: begin
        if (cur_pos == 4'd4 && in_byte_r[6:0] != 7'd0) begin
          verdict_v  = 1'b1;
          verdict_st = ST_BAD_EXT;
        end else begin
          if (cur_pos == 4'd4) begin
            flag_nxt = in_byte_r;
            flag_v   = in_byte_r;
          end
          if (cur_pos >= 4'd9) begin
            if (flag_v[7]) begin
              tag_nxt   = (cur_tag > CRC_DATA_BYTES) ? cur_tag - CRC_DATA_BYTES : '0;
              phase_nxt = PH_CRC;
              pos_nxt   = '0;
            end else begin
              enter = 1'b1;
            end
          end
        end
      end
      PH_CRC: begin
        if (cur_pos >= 4'd3) begin
          enter = 1'b1;
        end
      end
      PH_FID: begin
        id_nxt = {cur_id[23:0], in_byte_r};
        if (cur_pos >= 4'd3) begin
          phase_nxt = PH_FSIZE;
          pos_nxt   = '0;
          flen_nxt  = '0;
        end
      end
      PH_FSIZE: begin
        flen_nxt = flen_new;
        if (cur_pos >= 4'd3) begin
          pos_nxt = '0;
          if (cur_id == wanted_id_r) begin
            phase_nxt = PH_FFLAGS;
          end else if (need >= {3'b000, cur_tag}) begin
            verdict_v  = 1'b1;
            verdict_st = ST_ABSENT;
          end else begin
            tag_nxt   = cur_tag - need[29:0];
            skip_nxt  = flen_new[29:0] + FRAME_TAIL_BYTES;
            phase_nxt = PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        if (cur_skip != '0) begin
          skip_nxt = cur_skip - 30'd1;
        end
        if (cur_skip <= 30'd1) begin
          phase_nxt = PH_FID;
          pos_nxt   = '0;
          id_nxt    = '0;
        end
      end
      PH_FFLAGS: begin
        if (cur_pos >= 4'd1) begin
          if (in_byte_r[7:6] != 2'b00) begin
            verdict_v  = 1'b1;
            verdict_st = ST_FRAME_FLAGS;
          end else begin
            phase_nxt = PH_ENC;
            pos_nxt   = '0;
          end
        end
      end
      PH_ENC: begin
        if (in_byte_r != 8'd0) begin
          verdict_v  = 1'b1;
          verdict_st = ST_ENCODING;
        end else if (cur_flen < 32'(YEAR_CHARS + 1)) begin
          verdict_v  = 1'b1;
          verdict_st = ST_SHORT;
        end else begin
          flen_nxt  = cur_flen - 32'd1;
          phase_nxt = PH_YEAR;
          pos_nxt   = '0;
          year_nxt  = '0;
        end
      end
      PH_YEAR: begin
        year_nxt = year_new;
        if ({1'b0, cur_pos} + 5'd1 >= 5'(YEAR_CHARS)) begin
          if (cur_flen > 32'(YEAR_CHARS)) begin
            phase_nxt = PH_TERM;
            pos_nxt   = '0;
          end else begin
            verdict_v    = 1'b1;
            verdict_st   = ST_FOUND;
            verdict_year = year_new;
          end
        end
      end
      PH_TERM: begin
        verdict_v = 1'b1;
        if (in_byte_r == 8'd0) begin
          verdict_st   = ST_FOUND;
          verdict_year = cur_year;
        end else begin
          verdict_st = ST_TERM;
        end
      end
      default: begin
        // Idle: the byte is ignored.
        pos_nxt = cur_pos;
      end
    endcase

    // Frame walk starts only while tag bytes remain.
    if (enter) begin
      if (tag_avail == '0) begin
        verdict_v  = 1'b1;
        verdict_st = ST_ABSENT;
      end else begin
        phase_nxt = PH_FID;
        pos_nxt   = '0;
        id_nxt    = '0;
      end
    end

    // An end of stream that decides nothing else is a truncation.
    if (!verdict_v && in_eos_r && cur_phase != PH_IDLE) begin
      verdict_v  = 1'b1;
      verdict_st = ST_TRUNC;
    end

    if (verdict_v) begin
      phase_nxt = PH_IDLE;
      pos_nxt   = '0;
    end
  end

  // Parser state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      pos_r   <= '0;
      tag_r   <= '0;
      flen_r  <= '0;
      flag_r  <= '0;
      id_r    <= '0;
      year_r  <= '0;
      skip_r  <= '0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      tag_r   <= tag_nxt;
      flen_r  <= flen_nxt;
      flag_r  <= flag_nxt;
      id_r    <= id_nxt;
      year_r  <= year_nxt;
      skip_r  <= skip_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv && verdict_v) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && verdict_v) begin
      out_status_r <= verdict_st;
      out_year_r   <= verdict_year;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {4'b0000, out_year_r, out_status_r};

  // A verdict other than found carries no characters.
  a_year_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_status_r != ST_FOUND |-> out_year_r == 32'd0)
    else $error("year text nonzero on a failed verdict");

  // A verdict always returns the parser to idle.
  a_idle_after_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    adv && verdict_v |=> phase_r == PH_IDLE)
    else $error("parser not idle after verdict");

  // While skipping a frame body, the skip counter is never exhausted.
  a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_SKIP |-> skip_r != 30'd0)
    else $error("skip phase with empty counter");

  // A stalled input beat stays in the input register unchanged.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !adv |=> in_v_r && $stable(in_byte_r) && $stable(in_sos_r))
    else $error("input register lost a stalled beat");

endmodule

/* sim/tb_id3_year_frame_extractor_unit.sv */
// ----------------------------------------------------------------------------
// Testbench for the ID3 year frame extractor
// Feeds file byte streams (directed corner cases, then mostly well-formed
// ID3v2.3 tags with random content, mixed with noise and damaged streams)
// through the input stream. A byte-level parser model in the testbench
// predicts one verdict per stream, and each verdict beat on the result stream
// is checked against the oldest prediction. The run goes through several
// frame id settings and several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module tb_id3_year_frame_extractor_unit;
  import id3yfe_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 12;
  localparam int REPORT_LIMIT = 10;
  localparam int HOLD_CYCLES  = 400;

  localparam logic [7:0] TAG_MAGIC [3] = '{8'h49, 8'h44, 8'h33};

  typedef struct {
    logic [7:0] data;
    bit         is_first;
    bit         is_last;
    bit         hold_back;   // wait for all pending verdicts before sending
  } stream_byte_t;

  typedef struct {
    status_t     status;
    logic [31:0] year;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] data_byte
  logic        in_tuser = 1'b0; // [0] start_of_stream
  logic        in_tlast = 1'b0; // end_of_stream
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // [3:0] status, [35:4] year_text, [39:36] zero
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;

  id3_year_frame_extractor_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  // Parser model state.
  logic [31:0] want_id;
  phase_t      ph;
  logic [3:0]  fpos;
  logic [29:0] tag_left;
  logic [31:0] flen;
  logic [7:0]  fstore;
  logic [31:0] id_shift;
  logic [31:0] yr_shift;
  logic [31:0] skip_left;

  // Stimulus and expectation stores.
  stream_byte_t byte_q[$];
  verdict_t     verdict_q[$];
  logic [7:0]   scratch[$];
  bit           scratch_eos;
  stream_byte_t offered;

  int send_idle_pct;
  int recv_stall_pct;
  int hold_left = 0;
  bit hold_go   = 1'b0;
  bit hold_done = 1'b0;
  int cycle_count;
  int mismatch_count;
  int bytes_accepted;
  int verdicts_checked;
  int found_count;
  int settings_written;

  // --------------------------------------------------------------------------
  // Parser model
  // --------------------------------------------------------------------------
  function automatic void clear_parser();
    ph        = PH_IDLE;
    fpos      = '0;
    tag_left  = '0;
    flen      = '0;
    fstore    = '0;
    id_shift  = '0;
    yr_shift  = '0;
    skip_left = '0;
  endfunction

  // Start the frame walk, or give up at once when the tag has no room left.
  function automatic bit open_frame_walk(output status_t verdict);
    verdict = ST_ABSENT;
    if (tag_left == '0) return 1'b1;
    ph       = PH_FID;
    fpos     = '0;
    id_shift = '0;
    return 1'b0;
  endfunction

  // Advance the parser by one byte; returns 1 when the byte settles a verdict.
  function automatic bit parse_byte(input logic [7:0] b, input bit is_first,
                                    input bit is_last, output status_t verdict,
                                    output logic [31:0] year);
    logic [3:0]  pos;
    logic [32:0] need;
    bit          decided;
    decided = 1'b0;
    verdict = ST_FOUND;
    year    = '0;
    if (is_first) begin
      clear_parser();
      ph = PH_MAGIC;
    end
    if (ph == PH_IDLE) return 1'b0;
    pos  = fpos;
    fpos = fpos + 4'd1;
    case (ph)
      PH_MAGIC: begin
        if (pos > 4'd2) begin
          decided = 1'b1;
          verdict = ST_NO_TAG;
        end else if (b != TAG_MAGIC[pos[1:0]]) begin
          decided = 1'b1;
          verdict = ST_NO_TAG;
        end else if (pos == 4'd2) begin
          ph   = PH_VERSION;
          fpos = '0;
        end
      end
      PH_VERSION: begin
        if (pos >= 4'd1) begin
          ph   = PH_FLAGS;
          fpos = '0;
        end
      end
      PH_FLAGS: begin
        if (b[4:0] != '0) begin
          decided = 1'b1;
          verdict = ST_BAD_FLAGS;
        end else begin
          fstore   = b;
          ph       = PH_SIZE;
          fpos     = '0;
          tag_left = '0;
        end
      end
      PH_SIZE: begin
        // Syncsafe size: seven bits per byte, bit 7 dropped.
        tag_left = {tag_left[22:0], b[6:0]};
        if (pos >= 4'd3) begin
          if (fstore[6]) begin
            tag_left = (tag_left > EXT_HEADER_BYTES) ? tag_left - EXT_HEADER_BYTES : '0;
            ph       = PH_EXT;
            fpos     = '0;
          end else begin
            decided = open_frame_walk(verdict);
          end
        end
      end
      PH_EXT: begin
        if (pos == 4'd4 && b[6:0] != '0) begin
          decided = 1'b1;
          verdict = ST_BAD_EXT;
        end else begin
          if (pos == 4'd4) fstore = b;
          if (pos >= 4'd9) begin
            if (fstore[7]) begin
              tag_left = (tag_left > CRC_DATA_BYTES) ? tag_left - CRC_DATA_BYTES : '0;
              ph       = PH_CRC;
              fpos     = '0;
            end else begin
              decided = open_frame_walk(verdict);
            end
          end
        end
      end
      PH_CRC: begin
        if (pos >= 4'd3) decided = open_frame_walk(verdict);
      end
      PH_FID: begin
        id_shift = {id_shift[23:0], b};
        if (pos >= 4'd3) begin
          ph   = PH_FSIZE;
          fpos = '0;
          flen = '0;
        end
      end
      PH_FSIZE: begin
        flen = {flen[23:0], b};
        if (pos >= 4'd3) begin
          fpos = '0;
          if (id_shift == want_id) begin
            ph = PH_FFLAGS;
          end else begin
            // Skip a foreign frame only if it ends inside the tag.
            need = 33'd10 + {1'b0, flen};
            if (need >= {3'b000, tag_left}) begin
              decided = 1'b1;
              verdict = ST_ABSENT;
            end else begin
              tag_left  = tag_left - need[29:0];
              skip_left = flen + 32'd2;
              ph        = PH_SKIP;
            end
          end
        end
      end
      PH_SKIP: begin
        if (skip_left != '0) skip_left = skip_left - 32'd1;
        if (skip_left == '0) begin
          ph       = PH_FID;
          fpos     = '0;
          id_shift = '0;
        end
      end
      PH_FFLAGS: begin
        if (pos >= 4'd1) begin
          if (b[7:6] != '0) begin
            decided = 1'b1;
            verdict = ST_FRAME_FLAGS;
          end else begin
            ph   = PH_ENC;
            fpos = '0;
          end
        end
      end
      PH_ENC: begin
        if (b != '0) begin
          decided = 1'b1;
          verdict = ST_ENCODING;
        end else if (flen == '0) begin
          decided = 1'b1;
          verdict = ST_SHORT;
        end else begin
          flen = flen - 32'd1;
          if (flen < 32'(YEAR_CHARS)) begin
            decided = 1'b1;
            verdict = ST_SHORT;
          end else begin
            ph       = PH_YEAR;
            fpos     = '0;
            yr_shift = '0;
          end
        end
      end
      PH_YEAR: begin
        yr_shift = {yr_shift[23:0], b};
        if (int'(pos) + 1 >= YEAR_CHARS) begin
          if (flen > 32'(YEAR_CHARS)) begin
            ph   = PH_TERM;
            fpos = '0;
          end else begin
            decided = 1'b1;
            verdict = ST_FOUND;
          end
        end
      end
      PH_TERM: begin
        decided = 1'b1;
        verdict = (b == '0) ? ST_FOUND : ST_TERM;
      end
      default: ;
    endcase
    // A last byte that settles nothing means the file ended too early.
    if (!decided && is_last) begin
      decided = 1'b1;
      verdict = ST_TRUNC;
    end
    if (!decided) return 1'b0;
    if (verdict == ST_FOUND) year = yr_shift;
    ph   = PH_IDLE;
    fpos = '0;
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Stream builders
  // --------------------------------------------------------------------------
  // Appends one byte to the stream under construction.
  function automatic void add_byte(input logic [7:0] b);
    scratch.insert(scratch.size(), b);
  endfunction

  function automatic void push_word(input logic [31:0] w);
    for (int k = 3; k >= 0; k--) add_byte(w[8*k +: 8]);
  endfunction

  function automatic void push_random(input int n);
    for (int k = 0; k < n; k++) add_byte(8'($urandom));
  endfunction

  // Moves the scratch bytes onto the send queue; returns the bytes moved.
  function automatic int push_stream(input bit opens, input bit hold);
    stream_byte_t sb;
    int n;
    n = scratch.size();
    for (int k = 0; k < n; k++) begin
      sb.data      = scratch[k];
      sb.is_first  = opens && (k == 0);
      sb.is_last   = scratch_eos && (k == n - 1);
      sb.hold_back = hold && (k == 0);
      byte_q.insert(byte_q.size(), sb);
    end
    // Occasionally a stray byte or two while the parser sits idle.
    if (scratch_eos && $urandom_range(99) < 10) begin
      for (int k = $urandom_range(1, 2); k > 0; k--) begin
        sb.data      = 8'($urandom);
        sb.is_first  = 1'b0;
        sb.is_last   = 1'($urandom_range(1));
        sb.hold_back = 1'b0;
        byte_q.insert(byte_q.size(), sb);
      end
    end
    scratch.delete();
    return n;
  endfunction

  // A plausible tag: header, optional extended header, foreign frames, then
  // the wanted frame, with occasional damage and truncation.
  function automatic void build_tag();
    int unsigned n_other, wlen, ext_len, tag_size, cut;
    int unsigned olen[4];
    logic [31:0] oid;
    logic [7:0]  hflags, eflags, sb;
    int r;
    scratch = '{8'h49, 8'h44, 8'h33};
    push_random(2);
    r = $urandom_range(99);
    hflags = (r < 45) ? 8'h00 : (r < 70) ? 8'h40 :
             (r < 90) ? {3'($urandom), 5'b00000} : 8'($urandom);
    add_byte(hflags);
    r = $urandom_range(99);
    eflags  = (r < 45) ? 8'h00 : (r < 85) ? 8'h80 : 8'($urandom);
    ext_len = hflags[6] ? (eflags[7] ? 14 : 10) : 0;
    n_other = $urandom_range(0, 3);
    r = $urandom_range(99);
    wlen = (r < 55) ? 5 : (r < 80) ? $urandom_range(6, 8) :
           (r < 95) ? $urandom_range(0, 4) : 32'hFFFF_FFFF;
    tag_size = ext_len + 10 + ((wlen <= 8) ? wlen : 8) + $urandom_range(0, 8);
    for (int k = 0; k < n_other; k++) begin
      olen[k]  = $urandom_range(0, 6);
      tag_size += 10 + olen[k];
    end
    r = $urandom_range(99);
    if (r < 10) tag_size = $urandom_range(0, 14);
    else if (r < 14) tag_size = $urandom & 32'h0FFF_FFFF;
    for (int k = 3; k >= 0; k--) begin
      sb = 8'((tag_size >> (7 * k)) & 32'h7F);
      if ($urandom_range(3) == 0) sb[7] = 1'b1;
      add_byte(sb);
    end
    if (hflags[6]) begin
      push_random(4);
      add_byte(eflags);
      push_random(eflags[7] ? 9 : 5);
    end
    for (int k = 0; k < n_other; k++) begin
      oid = $urandom;
      if (oid == want_id) oid[0] = ~oid[0];
      push_word(oid);
      push_word(olen[k]);
      push_random(2 + olen[k]);
    end
    push_word(want_id);
    push_word(wlen);
    add_byte(8'($urandom));
    add_byte(($urandom_range(99) < 80) ? {2'b00, 6'($urandom)} : 8'($urandom));
    add_byte(($urandom_range(99) < 90) ? 8'h00 : 8'($urandom_range(1, 255)));
    for (int k = 0; k < YEAR_CHARS; k++) begin
      add_byte(($urandom_range(99) < 70) ? 8'h30 + 8'($urandom_range(9))
                                         : 8'($urandom));
    end
    if (wlen > 5) begin
      add_byte(($urandom_range(99) < 85) ? 8'h00 : 8'($urandom_range(1, 255)));
      if (wlen <= 8) push_random(wlen - 6);
    end
    push_random($urandom_range(0, 3));
    // Damage one byte now and then.
    if ($urandom_range(99) < 12) scratch[$urandom_range(scratch.size() - 1)] = 8'($urandom);
    if ($urandom_range(99) < 10) begin
      cut = $urandom_range(1, scratch.size());
      while (scratch.size() > cut) void'(scratch.pop_back());
      scratch_eos = 1'b1;
    end else begin
      scratch_eos = ($urandom_range(99) < 80);
    end
  endfunction

  // Random bytes, sometimes opening with part of the tag identifier.
  function automatic void build_noise();
    int keep;
    keep = ($urandom_range(99) < 30) ? $urandom_range(1, 3) : 0;
    for (int k = 0; k < keep; k++) add_byte(TAG_MAGIC[k]);
    push_random($urandom_range(1, 12));
    scratch_eos = 1'($urandom_range(1));
  endfunction

  // One byte that is not the first identifier character.
  function automatic void build_bad_magic();
    logic [7:0] b;
    b = 8'($urandom_range(0, 254));
    if (b >= 8'h49) b = b + 8'd1;
    add_byte(b);
    scratch_eos = 1'($urandom_range(1));
  endfunction

  function automatic void fill_random(input int target, input int pause_at);
    int added, r;
    bit paused, hold;
    added  = 0;
    paused = 1'b0;
    while (added < target) begin
      hold = !paused && (added >= pause_at);
      if (hold) paused = 1'b1;
      r = $urandom_range(99);
      if (r < 72) build_tag();
      else if (r < 90) build_noise();
      else build_bad_magic();
      added += push_stream(1'b1, hold);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Sequencing helpers
  // --------------------------------------------------------------------------
  task automatic write_frame_id(input logic [31:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    want_id = value;
    settings_written++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (byte_q.size() != 0 || in_tvalid || verdict_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic void note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) $display("Mismatch: %s", msg);
  endfunction

  // --------------------------------------------------------------------------
  // Input driver: offers the next queued byte and runs the model on each
  // accepted beat.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    status_t     st;
    logic [31:0] yr;
    verdict_t    v;
    bit          busy;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      busy = in_tvalid;
      if (in_tvalid && in_tready) begin
        busy = 1'b0;
        bytes_accepted++;
        if (parse_byte(offered.data, offered.is_first, offered.is_last, st, yr)) begin
          v.status = st;
          v.year   = yr;
          verdict_q.insert(verdict_q.size(), v);
        end
      end
      if (!busy) begin
        if (byte_q.size() != 0 && !(byte_q[0].hold_back && verdict_q.size() != 0) &&
            $urandom_range(99) >= send_idle_pct) begin
          offered = byte_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= offered.data;
          in_tuser  <= offered.is_first;
          in_tlast  <= offered.is_last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off countdown, started once on request.
  always @(posedge clk) begin
    if (hold_go && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: checks each verdict beat against the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    verdict_t exp_v;
    if (rst_n && out_tvalid && out_tready) begin
      verdicts_checked++;
      if (verdict_q.size() == 0) begin
        note_mismatch($sformatf("verdict with none pending: status %0d year %h",
                                out_tdata[3:0], out_tdata[35:4]));
      end else begin
        exp_v = verdict_q.pop_front();
        if (exp_v.status == ST_FOUND) found_count++;
        if (out_tdata[3:0] != exp_v.status)
          note_mismatch($sformatf("status expected %0d got %0d",
                                  exp_v.status, out_tdata[3:0]));
        if (out_tdata[35:4] != exp_v.year)
          note_mismatch($sformatf("year_text expected %h got %h",
                                  exp_v.year, out_tdata[35:4]));
        if (out_tdata[39:36] != '0)
          note_mismatch($sformatf("padding bits expected 0 got %h", out_tdata[39:36]));
      end
    end
    out_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d verdicts pending",
             cycle_count, verdict_q.size());
    $display("FAILED: results differ");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int dummy;
    rst_n            = 1'b0;
    cfg_valid        = 1'b0;
    cfg_data         = '0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    mismatch_count   = 0;
    bytes_accepted   = 0;
    verdicts_checked = 0;
    found_count      = 0;
    settings_written = 0;
    want_id          = DEFAULT_FRAME_ID;
    clear_parser();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Default setting, no idling, directed corner cases first.
    write_frame_id(DEFAULT_FRAME_ID);
    // Bytes before any stream start are ignored.
    scratch = '{8'h00, 8'hFF};
    scratch_eos = 1'b0;
    dummy = push_stream(1'b0, 1'b0);
    // Wrong first byte that is also the last byte: no tag, not truncated.
    scratch = '{8'h58};
    scratch_eos = 1'b1;
    dummy = push_stream(1'b1, 1'b0);
    // Identifier differs at its last character.
    scratch = '{8'h49, 8'h44, 8'h34};
    scratch_eos = 1'b1;
    dummy = push_stream(1'b1, 1'b0);
    // File ends after the first byte.
    scratch = '{8'h49};
    scratch_eos = 1'b1;
    dummy = push_stream(1'b1, 1'b0);
    // Reserved header flag bits set.
    scratch = '{8'h49, 8'h44, 8'h33, 8'h03, 8'h00, 8'h1F};
    scratch_eos = 1'b0;
    dummy = push_stream(1'b1, 1'b0);
    // Zero tag size: frame absent right after the size bytes.
    scratch = '{8'h49, 8'h44, 8'h33, 8'h03, 8'h00, 8'h00, 8'h80, 8'h80, 8'h80, 8'h80};
    scratch_eos = 1'b0;
    dummy = push_stream(1'b1, 1'b0);
    fill_random(230, 120);
    wait_drained();

    // All-zero frame id, sender idling.
    send_idle_pct = 49;
    write_frame_id(32'h0000_0000);
    fill_random(260, 130);
    wait_drained();

    // All-ones frame id, receiver stalling.
    send_idle_pct  = 0;
    recv_stall_pct = 49;
    write_frame_id(32'hFFFF_FFFF);
    fill_random(260, 130);
    wait_drained();

    // Random frame id, both sides idling, with a long receiver hold-off while
    // a burst of one-byte streams backs up the block.
    send_idle_pct  = 16;
    recv_stall_pct = 16;
    write_frame_id($urandom);
    hold_go = 1'b1;
    for (int k = 0; k < 40; k++) begin
      build_bad_magic();
      dummy = push_stream(1'b1, 1'b0);
    end
    fill_random(260, 140);
    wait_drained();

    // Back to the default id with no idling.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_frame_id(DEFAULT_FRAME_ID);
    fill_random(300, 150);
    wait_drained();

    $display("Run covered %0d bytes, %0d verdicts (%0d with the frame found)",
             bytes_accepted, verdicts_checked, found_count);
    $display("over %0d frame id settings; %0d mismatches", settings_written, mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
